@@ hdl/tcp_segment_checksum_top_macros.svh @@
// Assertion macros shared by the checksum block.
// Include with the bare file name; needs no package.
`ifndef TCP_SEGMENT_CHECKSUM_TOP_MACROS_SVH
`define TCP_SEGMENT_CHECKSUM_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TCPC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tcpc check failed");
`define TCPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcpc check failed");
`else
`define TCPC_ASSERT(lbl, clk, rst_n, prop)
`define TCPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ hdl/tcpc_pkg.sv @@
// Types and constants for the TCP segment checksum block.
// No dependencies.
package tcpc_pkg;

    localparam logic [15:0] MAX_SEGMENT_BYTES = 16'd65535;
    localparam logic [15:0] HDR_BYTES         = 16'd20;
    localparam logic [15:0] HDR_LEN           =
        (MAX_SEGMENT_BYTES < HDR_BYTES) ? MAX_SEGMENT_BYTES : HDR_BYTES;
    localparam logic [15:0] CSUM_ALL_ONES     = 16'hFFFF;

    typedef enum logic {
        KIND_HEADER  = 1'b0,
        KIND_PAYLOAD = 1'b1
    } tcpc_kind_t;

    // One classified request between front and back
    typedef struct packed {
        tcpc_kind_t  kind;
        logic        last;
        logic [19:0] hdr_sum;
        logic [15:0] pseudo;
        logic [7:0]  data;
    } tcpc_item_t;

    // One finished segment, sum not yet folded
    typedef struct packed {
        logic [20:0] raw_sum;
        logic [15:0] seg_len;
        logic        too_long;
    } tcpc_result_t;

endpackage

@@ hdl/tcpc_front.sv @@
// Front stage: registers each input request and pre-sums header words.
// Depends on tcpc_pkg.
module tcpc_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [15:0]        src_port,
    input  logic [15:0]        dst_port,
    input  logic [31:0]        seq_number,
    input  logic [31:0]        ack_number,
    input  logic [3:0]         data_offset,
    input  logic [7:0]         flag_bits,
    input  logic [15:0]        window,
    input  logic [15:0]        urgent_ptr,
    input  logic [31:0]        pseudo_sum,
    input  logic [7:0]         payload_byte,
    input  logic               last_item,
    output logic               item_valid,
    input  logic               item_ready,
    output tcpc_pkg::tcpc_item_t item
);
    import tcpc_pkg::*;

    logic        valid_reg, valid_next;
    tcpc_item_t  item_reg, item_next;
    logic        load;
    logic [19:0] hsum;
    logic [16:0] pfold;

    // Nine big-endian header words, checksum field taken as zero
    assign hsum = 20'(src_port) + 20'(dst_port)
                + 20'(seq_number[31:16]) + 20'(seq_number[15:0])
                + 20'(ack_number[31:16]) + 20'(ack_number[15:0])
                + 20'({data_offset, 4'b0000, flag_bits})
                + 20'(window) + 20'(urgent_ptr);

    assign pfold = {1'b0, pseudo_sum[31:16]} + {1'b0, pseudo_sum[15:0]};

    assign full = valid_reg && !item_ready;
    assign load = push && !full;

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (load)
        begin
            valid_next        = 1'b1;
            item_next.kind    = tcpc_kind_t'(kind);
            item_next.last    = last_item;
            item_next.hdr_sum = hsum;
            item_next.pseudo  = pfold[15:0] + {15'b0, pfold[16]};
            item_next.data    = payload_byte;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ hdl/tcpc_queue.sv @@
// Two-entry request queue between front and back.
// Depends on tcpc_pkg and the assertion macro header.
`include "tcp_segment_checksum_top_macros.svh"

module tcpc_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcpc_pkg::tcpc_item_t in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tcpc_pkg::tcpc_item_t out_item
);
    import tcpc_pkg::*;

    tcpc_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       wr_en, rd_en;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_en ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `TCPC_ASSERT(a_q_count_range, clk, rst_n, count_reg != 2'd3)
    `TCPC_ASSERT(a_q_ptr_gap, clk, rst_n,
        (count_reg != 2'd1) || (wr_ptr_reg != rd_ptr_reg))
    `TCPC_ASSERT_NEXT(a_q_fill, clk, rst_n, wr_en && !rd_en,
        count_reg == $past(count_reg) + 2'd1)

endmodule

@@ hdl/tcpc_back.sv @@
// Back stage: ones-complement accumulator, length count and result queue.
// Depends on tcpc_pkg and the assertion macro header.
`include "tcp_segment_checksum_top_macros.svh"

module tcpc_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  tcpc_pkg::tcpc_item_t item,
    output logic                 empty,
    input  logic                 pop,
    output logic [15:0]          checksum,
    output logic [15:0]          segment_length,
    output logic                 too_long
);
    import tcpc_pkg::*;

    logic [15:0] acc_reg, acc_next;
    logic [7:0]  held_reg, held_next;
    logic        odd_reg, odd_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] psum_reg, psum_next;
    logic        ovf_reg, ovf_next;

    tcpc_result_t rq_mem_reg [2];
    logic         rq_wr_ptr_reg, rq_rd_ptr_reg;
    logic [1:0]   rq_count_reg, rq_count_next;
    logic         rq_full, rq_push, rq_pop;
    tcpc_result_t res;
    tcpc_result_t head;

    logic        take, drop;
    logic [16:0] hfold;
    logic [15:0] hacc;
    logic [15:0] pair;
    logic [16:0] pair_sum;
    logic [15:0] pair_acc;
    logic [15:0] tail_word;
    logic [16:0] ofold1;
    logic [15:0] ofold2;
    logic [15:0] inv;

    assign rq_full    = (rq_count_reg == 2'd2);
    // Stall only a final request that has nowhere to put its result
    assign take       = item_valid && !(item.last && rq_full);
    assign item_ready = !(item.last && rq_full);
    assign rq_push    = take && item.last;
    assign rq_pop     = pop && !empty;
    assign empty      = (rq_count_reg == 2'd0);

    assign drop = (count_reg >= MAX_SEGMENT_BYTES);

    assign hfold    = {1'b0, item.hdr_sum[15:0]} + {13'b0, item.hdr_sum[19:16]};
    assign hacc     = hfold[15:0] + {15'b0, hfold[16]};
    assign pair     = {held_reg, item.data};
    assign pair_sum = {1'b0, acc_reg} + {1'b0, pair};
    assign pair_acc = pair_sum[15:0] + {15'b0, pair_sum[16]};

    // Word still to add when the segment closes on a payload byte
    always_comb
    begin
        if (drop)
        begin
            tail_word = odd_reg ? {held_reg, 8'h00} : 16'h0000;
        end
        else
        begin
            tail_word = odd_reg ? pair : {item.data, 8'h00};
        end
    end

    always_comb
    begin
        res = '0;
        case (item.kind)
            KIND_HEADER:
            begin
                res.raw_sum  = 21'(item.hdr_sum) + 21'(item.pseudo);
                res.seg_len  = HDR_LEN;
                res.too_long = 1'b0;
            end
            KIND_PAYLOAD:
            begin
                res.raw_sum  = 21'(acc_reg) + 21'(tail_word) + 21'(psum_reg);
                res.seg_len  = drop ? count_reg : count_reg + 16'd1;
                res.too_long = ovf_reg || drop;
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_comb
    begin
        acc_next   = acc_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        count_next = count_reg;
        psum_next  = psum_reg;
        ovf_next   = ovf_reg;
        if (take)
        begin
            if (item.last)
            begin
                acc_next   = '0;
                held_next  = '0;
                odd_next   = 1'b0;
                count_next = '0;
                psum_next  = '0;
                ovf_next   = 1'b0;
            end
            else
            begin
                case (item.kind)
                    KIND_HEADER:
                    begin
                        acc_next   = hacc;
                        held_next  = '0;
                        odd_next   = 1'b0;
                        count_next = HDR_LEN;
                        psum_next  = item.pseudo;
                        ovf_next   = 1'b0;
                    end
                    KIND_PAYLOAD:
                    begin
                        if (drop)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 16'd1;
                            if (odd_reg)
                            begin
                                acc_next  = pair_acc;
                                held_next = '0;
                                odd_next  = 1'b0;
                            end
                            else
                            begin
                                held_next = item.data;
                                odd_next  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        acc_next = acc_reg;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        rq_count_next = rq_count_reg;
        if (rq_push && !rq_pop)
        begin
            rq_count_next = rq_count_reg + 2'd1;
        end
        else if (rq_pop && !rq_push)
        begin
            rq_count_next = rq_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            held_reg      <= '0;
            odd_reg       <= 1'b0;
            count_reg     <= '0;
            psum_reg      <= '0;
            ovf_reg       <= 1'b0;
            rq_wr_ptr_reg <= 1'b0;
            rq_rd_ptr_reg <= 1'b0;
            rq_count_reg  <= 2'd0;
        end
        else
        begin
            acc_reg       <= acc_next;
            held_reg      <= held_next;
            odd_reg       <= odd_next;
            count_reg     <= count_next;
            psum_reg      <= psum_next;
            ovf_reg       <= ovf_next;
            rq_wr_ptr_reg <= rq_push ? ~rq_wr_ptr_reg : rq_wr_ptr_reg;
            rq_rd_ptr_reg <= rq_pop ? ~rq_rd_ptr_reg : rq_rd_ptr_reg;
            rq_count_reg  <= rq_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rq_push)
        begin
            rq_mem_reg[rq_wr_ptr_reg] <= res;
        end
    end

    // Fold the head result to 16 bits, invert, and map zero to all ones
    assign head   = rq_mem_reg[rq_rd_ptr_reg];
    assign ofold1 = {1'b0, head.raw_sum[15:0]} + {12'b0, head.raw_sum[20:16]};
    assign ofold2 = ofold1[15:0] + {15'b0, ofold1[16]};
    assign inv    = ~ofold2;

    assign checksum       = (inv == 16'h0000) ? CSUM_ALL_ONES : inv;
    assign segment_length = head.seg_len;
    assign too_long       = head.too_long;

    `TCPC_ASSERT(a_b_rq_range, clk, rst_n, rq_count_reg != 2'd3)
    `TCPC_ASSERT_NEXT(a_b_clear_after_last, clk, rst_n, rq_push,
        (count_reg == 16'd0) && !odd_reg && !ovf_reg && (acc_reg == 16'd0))
    `TCPC_ASSERT(a_b_ovf_at_max, clk, rst_n,
        !ovf_reg || (count_reg == MAX_SEGMENT_BYTES))
    `TCPC_ASSERT_NEXT(a_b_result_queued, clk, rst_n, rq_push && !rq_pop,
        !empty)

endmodule

@@ hdl/tcp_segment_checksum_top.sv @@
// Top level of the TCP segment checksum block.
// Depends on tcpc_pkg, tcpc_front, tcpc_queue and tcpc_back.
//
//   channel   handshake      payload
//   -------   ------------   ---------------------------------------------
//   request   push / full    kind, header fields, payload_byte, last_item
//   result    pop / empty    checksum, segment_length, too_long
//
// One request per cycle while no final request waits on a full result
// queue; the back stage adds one ones-complement word per pair of payload bytes.
// A result is on the ports once it is in the result queue and at its head.
// Reset clears all segment state and both queues; no clearing pass.
// Only a final request stalls the back stage, and only while two results wait.
module tcp_segment_checksum_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        kind,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [31:0] seq_number,
    input  logic [31:0] ack_number,
    input  logic [3:0]  data_offset,
    input  logic [7:0]  flag_bits,
    input  logic [15:0] window,
    input  logic [15:0] urgent_ptr,
    input  logic [31:0] pseudo_sum,
    input  logic [7:0]  payload_byte,
    input  logic        last_item,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] checksum,
    output logic [15:0] segment_length,
    output logic        too_long
);
    import tcpc_pkg::*;

    logic       f_valid, f_ready;
    tcpc_item_t f_item;
    logic       b_valid, b_ready;
    tcpc_item_t b_item;

    tcpc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .kind         (kind),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .seq_number   (seq_number),
        .ack_number   (ack_number),
        .data_offset  (data_offset),
        .flag_bits    (flag_bits),
        .window       (window),
        .urgent_ptr   (urgent_ptr),
        .pseudo_sum   (pseudo_sum),
        .payload_byte (payload_byte),
        .last_item    (last_item),
        .item_valid   (f_valid),
        .item_ready   (f_ready),
        .item         (f_item)
    );

    tcpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    tcpc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (b_valid),
        .item_ready     (b_ready),
        .item           (b_item),
        .empty          (empty),
        .pop            (pop),
        .checksum       (checksum),
        .segment_length (segment_length),
        .too_long       (too_long)
    );

endmodule
